[hw/rtl/dark_pixel_extreme_points_unit_macros.svh]
// ----------------------------------------------------------------------------
// dark pixel extreme points unit - assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef DARK_PIXEL_EXTREME_POINTS_UNIT_MACROS_SVH
`define DARK_PIXEL_EXTREME_POINTS_UNIT_MACROS_SVH

// same-cycle implication
`define DPEP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPEP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dpep_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpep_pkg
// types and fixed constants of the dark pixel extreme points unit
// ----------------------------------------------------------------------------
package dpep_pkg;

	localparam int CHAN_W      = 8;
	localparam int SIZE_W      = 12;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int COORD_OUT_W = 11;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CHAN_W-1:0] DARK_THRESHOLD_RST = 8'd10;
	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST    = 12'd640;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST   = 12'd480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DARK_THRESHOLD = 2'd0,
		CFG_FRAME_WIDTH    = 2'd1,
		CFG_FRAME_HEIGHT   = 2'd2
	} cfg_index_t;

	// per-pixel classification passed from front to back
	typedef struct packed {
		logic dark;
		logic frame_end;
	} item_flags_t;

endpackage

[hw/rtl/dark_pixel_extreme_points_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_pixel_extreme_points_unit
// top, bottom, left and right dark pixel points of a raster-order frame
// ----------------------------------------------------------------------------
// pixel channel: push with chan_blue/green/red, taken when push and not full
// result channel: one word per frame on the frame's last pixel, shown while
//   empty is low and taken when pop and not empty
// config: cfg_we with cfg_index and cfg_data writes a register at once;
//   write only while no frame work is outstanding
// throughput: one pixel per clock while not full; front classifies and counts,
//   a four-word queue feeds the tracker, set by the one-word result register
// a last pixel passes the queue, then the result register drives empty low
// receiver stall: pixels keep flowing while a result waits; the tracker
//   halts only at the next frame's last pixel, and full rises once the
//   queue behind it has filled
// reset: config returns to threshold 10 and 640 x 480, counters and
//   tracking clear, queue and result register are empty
// ----------------------------------------------------------------------------
`include "dark_pixel_extreme_points_unit_macros.svh"

module dark_pixel_extreme_points_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpep_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dpep_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic [dpep_pkg::CHAN_W-1:0]       chan_blue,
	input  logic [dpep_pkg::CHAN_W-1:0]       chan_green,
	input  logic [dpep_pkg::CHAN_W-1:0]       chan_red,
	output logic                              empty,
	input  logic                              pop,
	output logic                              found,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  top_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  top_col,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  bottom_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  bottom_col,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  left_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  left_col,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  right_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  right_col
);
	import dpep_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DW = $bits(item_flags_t) + RW + CW;

	logic          accept;
	item_flags_t   fr_flags, hd_flags;
	logic [RW-1:0] fr_row, hd_row;
	logic [CW-1:0] fr_col, hd_col;
	logic [DW-1:0] q_head;
	logic          q_empty;
	logic          q_pop;
	logic          res_valid;
	logic          last_taken;
	logic          points_zero;
	logic          points_ordered;

	assign accept = push && !full;
	assign empty  = !res_valid;

	dpep_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.chan_blue (chan_blue),
		.chan_green(chan_green),
		.chan_red  (chan_red),
		.item_flags(fr_flags),
		.item_row  (fr_row),
		.item_col  (fr_col)
	);

	dpep_queue #(
		.DW   (DW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data({fr_flags, fr_row, fr_col}),
		.rd_en  (q_pop),
		.full   (full),
		.empty  (q_empty),
		.rd_data(q_head)
	);

	assign {hd_flags, hd_row, hd_col} = q_head;

	dpep_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(!q_empty),
		.head_flags(hd_flags),
		.head_row  (hd_row),
		.head_col  (hd_col),
		.head_take (q_pop),
		.res_pop   (pop),
		.res_valid (res_valid),
		.found     (found),
		.top_row   (top_row),
		.top_col   (top_col),
		.bottom_row(bottom_row),
		.bottom_col(bottom_col),
		.left_row  (left_row),
		.left_col  (left_col),
		.right_row (right_row),
		.right_col (right_col)
	);

	assign last_taken     = q_pop && hd_flags.frame_end;
	assign points_zero    = (top_row == '0) && (top_col == '0) &&
	                        (bottom_row == '0) && (bottom_col == '0) &&
	                        (left_row == '0) && (left_col == '0) &&
	                        (right_row == '0) && (right_col == '0);
	assign points_ordered = (left_col <= right_col) && (top_row <= bottom_row) &&
	                        (left_col <= top_col);

	`DPEP_ASSERT_NEXT(a_frame_end_gives_word, last_taken, !empty, "frame end lost")
	`DPEP_ASSERT_NOW(a_not_found_zero, !empty && !found, points_zero, "points without dark pixel")
	`DPEP_ASSERT_NOW(a_found_order, !empty && found, points_ordered, "extreme points out of order")

endmodule

[hw/rtl/dpep_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpep_front
// config registers, raster counters and dark classification of each pixel
// ----------------------------------------------------------------------------
module dpep_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpep_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dpep_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              accept,
	input  logic [dpep_pkg::CHAN_W-1:0]       chan_blue,
	input  logic [dpep_pkg::CHAN_W-1:0]       chan_green,
	input  logic [dpep_pkg::CHAN_W-1:0]       chan_red,
	output dpep_pkg::item_flags_t             item_flags,
	output logic [$clog2(MAX_HEIGHT)-1:0]     item_row,
	output logic [$clog2(MAX_WIDTH)-1:0]      item_col
);
	import dpep_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CHAN_W-1:0] thr_q;
	logic [CW-1:0]     w_last_q;
	logic [RW-1:0]     h_last_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic              row_end;

	function automatic logic [CW-1:0] width_last(logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return '0;
		end else if (32'(v) > 32'(MAX_WIDTH)) begin
			return CW'(MAX_WIDTH - 1);
		end else begin
			return CW'(v - SIZE_W'(1));
		end
	endfunction

	function automatic logic [RW-1:0] height_last(logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return '0;
		end else if (32'(v) > 32'(MAX_HEIGHT)) begin
			return RW'(MAX_HEIGHT - 1);
		end else begin
			return RW'(v - SIZE_W'(1));
		end
	endfunction

	// config registers; width and height are stored as clamped last index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= DARK_THRESHOLD_RST;
			w_last_q <= width_last(FRAME_WIDTH_RST);
			h_last_q <= height_last(FRAME_HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DARK_THRESHOLD: thr_q    <= cfg_data[CHAN_W-1:0];
				CFG_FRAME_WIDTH:    w_last_q <= width_last(cfg_data[SIZE_W-1:0]);
				CFG_FRAME_HEIGHT:   h_last_q <= height_last(cfg_data[SIZE_W-1:0]);
				default: ;
			endcase
		end
	end

	assign row_end              = (col_q >= w_last_q);
	assign item_flags.frame_end = row_end && (row_q >= h_last_q);
	assign item_flags.dark      = (chan_blue < thr_q) || (chan_green < thr_q) ||
	                              (chan_red < thr_q);
	assign item_row             = row_q;
	assign item_col             = col_q;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (item_flags.frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

[hw/rtl/dpep_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpep_queue
// small first-in first-out buffer between front and back
// ----------------------------------------------------------------------------
module dpep_queue #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	output logic          full,
	output logic          empty,
	output logic [DW-1:0] rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DW-1:0] mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

[hw/rtl/dpep_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpep_back
// extreme point tracking per frame and the result word register
// ----------------------------------------------------------------------------
module dpep_back #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  dpep_pkg::item_flags_t             head_flags,
	input  logic [$clog2(MAX_HEIGHT)-1:0]     head_row,
	input  logic [$clog2(MAX_WIDTH)-1:0]      head_col,
	output logic                              head_take,
	input  logic                              res_pop,
	output logic                              res_valid,
	output logic                              found,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  top_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  top_col,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  bottom_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  bottom_col,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  left_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  left_col,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  right_row,
	output logic [dpep_pkg::COORD_OUT_W-1:0]  right_col
);
	import dpep_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic          any_q, any_n;
	logic [RW-1:0] top_r_q, bot_r_q, lft_r_q, rgt_r_q;
	logic [CW-1:0] top_c_q, bot_c_q, lft_c_q, rgt_c_q;
	logic [RW-1:0] top_r_n, bot_r_n, lft_r_n, rgt_r_n;
	logic [CW-1:0] top_c_n, bot_c_n, lft_c_n, rgt_c_n;
	logic          res_valid_q;
	logic          res_free;

	assign res_free  = !res_valid_q || res_pop;
	assign head_take = head_valid && (!head_flags.frame_end || res_free);
	assign res_valid = res_valid_q;

	always_comb begin
		any_n   = any_q;
		top_r_n = top_r_q; top_c_n = top_c_q;
		bot_r_n = bot_r_q; bot_c_n = bot_c_q;
		lft_r_n = lft_r_q; lft_c_n = lft_c_q;
		rgt_r_n = rgt_r_q; rgt_c_n = rgt_c_q;
		if (head_flags.dark) begin
			if (!any_q) begin
				any_n   = 1'b1;
				top_r_n = head_row; top_c_n = head_col;
				bot_r_n = head_row; bot_c_n = head_col;
				lft_r_n = head_row; lft_c_n = head_col;
				rgt_r_n = head_row; rgt_c_n = head_col;
			end else begin
				if (head_row > bot_r_q) begin
					bot_r_n = head_row; bot_c_n = head_col;
				end
				if (head_col < lft_c_q) begin
					lft_r_n = head_row; lft_c_n = head_col;
				end
				if (head_col > rgt_c_q) begin
					rgt_r_n = head_row; rgt_c_n = head_col;
				end
			end
		end
	end

	// tracking state, cleared after the frame's last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q   <= 1'b0;
			top_r_q <= '0; top_c_q <= '0;
			bot_r_q <= '0; bot_c_q <= '0;
			lft_r_q <= '0; lft_c_q <= '0;
			rgt_r_q <= '0; rgt_c_q <= '0;
		end else if (head_take) begin
			if (head_flags.frame_end) begin
				any_q   <= 1'b0;
				top_r_q <= '0; top_c_q <= '0;
				bot_r_q <= '0; bot_c_q <= '0;
				lft_r_q <= '0; lft_c_q <= '0;
				rgt_r_q <= '0; rgt_c_q <= '0;
			end else begin
				any_q   <= any_n;
				top_r_q <= top_r_n; top_c_q <= top_c_n;
				bot_r_q <= bot_r_n; bot_c_q <= bot_c_n;
				lft_r_q <= lft_r_n; lft_c_q <= lft_c_n;
				rgt_r_q <= rgt_r_n; rgt_c_q <= rgt_c_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (head_take && head_flags.frame_end) begin
			res_valid_q <= 1'b1;
		end else if (res_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (head_take && head_flags.frame_end) begin
			found      <= any_n;
			top_row    <= COORD_OUT_W'(top_r_n);
			top_col    <= COORD_OUT_W'(top_c_n);
			bottom_row <= COORD_OUT_W'(bot_r_n);
			bottom_col <= COORD_OUT_W'(bot_c_n);
			left_row   <= COORD_OUT_W'(lft_r_n);
			left_col   <= COORD_OUT_W'(lft_c_n);
			right_row  <= COORD_OUT_W'(rgt_r_n);
			right_col  <= COORD_OUT_W'(rgt_c_n);
		end
	end

endmodule
